FILE: sv/slps_pkg.sv
// Package for the status LED pattern sequencer.
// Holds the transaction structs, command codes, register indexes and the
// status pattern table. It has no dependencies.
`default_nettype none

package slps_pkg;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_SET_MAIN   = 2'd1,
    CMD_START_TEMP = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  localparam int PERIOD_W = 20;
  localparam int ELAPSED_W = 16;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_PHASE_PERIOD = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_INVERT_MASK  = 1'b1;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd125000;
  localparam logic [31:0] IDLE_PATTERN = 32'h6666_6666;

  typedef struct packed {
    logic [1:0]           cmd;
    logic [ELAPSED_W-1:0] elapsed;
    logic [2:0]           status;
    logic [7:0]           repeat_count;
  } in_t;

  typedef struct packed {
    logic [2:0] led_rgb;
    logic       led_update;
  } out_t;

  function automatic logic [31:0] status_pattern(input logic [2:0] status);
    logic [31:0] pat;
    case (status)
      3'd0:    pat = 32'h6666_6666;  // idle
      3'd1:    pat = 32'h4040_4040;  // error
      3'd2:    pat = 32'h6666_2222;  // usb ready
      3'd3:    pat = 32'h2222_2222;  // usb connected
      3'd4:    pat = 32'h1111_1111;  // card active
      default: pat = 32'h4646_4646;  // unknown status
    endcase
    return pat;
  endfunction

  function automatic logic [3:0] phase_nibble(input logic [31:0] bits,
                                              input logic [2:0] step);
    return bits[{step, 2'b00} +: 4];
  endfunction

endpackage

`default_nettype wire

FILE: sv/status_led_pattern_sequencer.sv
// Top level of the status LED pattern sequencer.
// Depends on slps_pkg and slps_timer.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one command per
//   transaction: a tick with elapsed time, a main status change, or the start
//   of a temporary status override. Every accepted transaction produces
//   exactly one result transaction on the output channel (out_valid,
//   out_stall, out_data) with the LED color and an update flag.
//   The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
//   writes the phase period and the RGB inversion mask; it is always ready
//   and should be written only while the block is idle.
//   The result is registered in the output register, or in the skid register
//   when the receiver stalls. Throughput is one transaction per cycle while
//   the receiver does not stall, set by the combinational timer add, compare
//   and pattern select. When the receiver stalls, the current result holds in
//   the output register and one more transaction is taken into a skid register;
//   after that in_stall rises until the skid register drains into the output.
//   Synchronous reset loads the idle pattern, clears both timers, cancels any
//   temporary override and restores the default period and mask.
`default_nettype none

module status_led_pattern_sequencer import slps_pkg::*; #(
  parameter int TIMER_BITS = 21
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_t                      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [REG_IDX_W-1:0] cfg_index,
  input  wire logic [PERIOD_W-1:0]  cfg_data
);

  localparam int CMP_W = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;

  // Configuration registers.
  logic [PERIOD_W-1:0] phase_period;
  logic [2:0]          invert_mask;

  // Sequencer state.
  logic [TIMER_BITS-1:0] main_time, main_time_next;
  logic [2:0]            main_step, main_step_next;
  logic                  main_unstarted, main_unstarted_next;
  logic [31:0]           main_bits, main_bits_next;
  logic [CMP_W-1:0]      temp_time, temp_time_next;
  logic [2:0]            temp_step, temp_step_next;
  logic [8:0]            temp_left, temp_left_next;
  logic [31:0]           temp_bits, temp_bits_next;

  // Output register and skid register.
  out_t result;
  logic skid_valid;
  out_t skid_data;

  logic             accept;
  logic             out_take;
  logic [CMP_W-1:0] main_timer_out;
  logic             main_reached;
  logic [CMP_W-1:0] temp_timer_out;
  logic             temp_reached;
  logic [31:0]      new_pattern;
  logic [3:0]       nib;

  assign accept    = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;
  assign in_stall  = skid_valid;
  assign cfg_ready = 1'b1;

  slps_timer #(.TIMER_BITS(TIMER_BITS)) u_main_timer (
    .time_cur  ({{(CMP_W - TIMER_BITS){1'b0}}, main_time}),
    .elapsed   (in_data.elapsed),
    .period    (phase_period),
    .time_next (main_timer_out),
    .reached   (main_reached)
  );

  slps_timer #(.TIMER_BITS(TIMER_BITS)) u_temp_timer (
    .time_cur  (temp_time),
    .elapsed   (in_data.elapsed),
    .period    (phase_period),
    .time_next (temp_timer_out),
    .reached   (temp_reached)
  );

  assign new_pattern = status_pattern(in_data.status);

  always_comb begin
    main_time_next      = main_time;
    main_step_next      = main_step;
    main_unstarted_next = main_unstarted;
    main_bits_next      = main_bits;
    temp_time_next      = temp_time;
    temp_step_next      = temp_step;
    temp_left_next      = temp_left;
    temp_bits_next      = temp_bits;
    nib                 = 4'd0;
    result              = '0;

    case (cmd_t'(in_data.cmd))
      CMD_TICK: begin
        logic show_main;
        logic show_temp;
        show_main = 1'b0;
        show_temp = 1'b0;
        main_time_next = main_timer_out[TIMER_BITS-1:0];
        if (main_reached) begin
          main_step_next      = main_step + 3'd1;
          main_unstarted_next = 1'b0;
          show_main           = 1'b1;
        end
        if (temp_left != 9'd0) begin
          show_temp      = 1'b1;
          temp_time_next = temp_timer_out;
          if (temp_reached) begin
            temp_left_next = temp_left - 9'd1;
            if (temp_left == 9'd1) begin
              // The override has run out: hand the LED back to the main pattern.
              show_temp = 1'b0;
              show_main = 1'b1;
            end else begin
              temp_step_next = temp_step + 3'd1;
            end
          end
        end
        if (show_temp) begin
          nib = phase_nibble(temp_bits, temp_step_next);
        end else if (show_main && !main_unstarted_next) begin
          nib = phase_nibble(main_bits, main_step_next);
        end
        if (show_temp || show_main) begin
          result.led_rgb    = nib[2:0] ^ invert_mask;
          result.led_update = 1'b1;
        end
      end
      CMD_SET_MAIN: begin
        main_bits_next      = new_pattern;
        main_step_next      = 3'd7;
        main_unstarted_next = 1'b1;
      end
      CMD_START_TEMP: begin
        if (in_data.repeat_count != 8'd0) begin
          temp_bits_next    = new_pattern;
          temp_step_next    = 3'd7;
          temp_time_next    = {{(CMP_W - PERIOD_W){1'b0}}, phase_period};
          temp_left_next    = {1'b0, in_data.repeat_count} + 9'd1;
          result.led_rgb    = new_pattern[2:0] ^ invert_mask;
          result.led_update = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_period <= PERIOD_RESET;
      invert_mask  <= 3'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PHASE_PERIOD: phase_period <= cfg_data;
        REG_INVERT_MASK:  invert_mask  <= cfg_data[2:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_time      <= '0;
      main_step      <= 3'd7;
      main_unstarted <= 1'b1;
      main_bits      <= IDLE_PATTERN;
      temp_time      <= '0;
      temp_step      <= 3'd0;
      temp_left      <= 9'd0;
      temp_bits      <= 32'd0;
    end else if (accept) begin
      main_time      <= main_time_next;
      main_step      <= main_step_next;
      main_unstarted <= main_unstarted_next;
      main_bits      <= main_bits_next;
      temp_time      <= temp_time_next;
      temp_step      <= temp_step_next;
      temp_left      <= temp_left_next;
      temp_bits      <= temp_bits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (out_valid && !out_take) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_take) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (out_valid && !out_take) begin
        skid_data <= result;
      end else begin
        out_data <= result;
      end
    end else if (out_take && skid_valid) begin
      out_data <= skid_data;
    end
  end

  // The skid register only fills behind a full, stalled output register.
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register is empty");

  // A result without an update never carries a color.
  a_no_update_dark: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.led_update) |-> (out_data.led_rgb == 3'd0))
    else $error("led_rgb nonzero without led_update");

  // A main pattern that has not started yet always sits at phase seven.
  a_unstarted_step: assert property (@(posedge clk) disable iff (rst)
    main_unstarted |-> (main_step == 3'd7))
    else $error("main pattern unstarted at a phase other than seven");

  // The override count never exceeds the largest repeat count plus one.
  a_temp_left_range: assert property (@(posedge clk) disable iff (rst)
    temp_left <= 9'd256)
    else $error("temporary phase count out of range");

endmodule

`default_nettype wire

FILE: sv/slps_timer.sv
// Phase timer step for the status LED pattern sequencer.
// Adds elapsed time with saturation and compares against the phase period.
// Depends on slps_pkg.
`default_nettype none

module slps_timer import slps_pkg::*; #(
  parameter int TIMER_BITS = 21
) (
  input  wire logic [((TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W)-1:0] time_cur,
  input  wire logic [ELAPSED_W-1:0]                                         elapsed,
  input  wire logic [PERIOD_W-1:0]                                          period,
  output logic      [((TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W)-1:0] time_next,
  output logic                                                              reached
);

  localparam int CMP_W = (TIMER_BITS > PERIOD_W) ? TIMER_BITS : PERIOD_W;
  localparam logic [CMP_W:0] TIMER_MAX =
    {{(CMP_W + 1 - TIMER_BITS){1'b0}}, {TIMER_BITS{1'b1}}};

  logic [CMP_W:0] sum;
  logic [CMP_W:0] sat;

  always_comb begin
    sum = {1'b0, time_cur} + {{(CMP_W + 1 - ELAPSED_W){1'b0}}, elapsed};
    sat = (sum > TIMER_MAX) ? TIMER_MAX : sum;
    reached = (sat >= {{(CMP_W + 1 - PERIOD_W){1'b0}}, period});
    time_next = reached ? '0 : sat[CMP_W-1:0];
  end

endmodule

`default_nettype wire
